FILE: hdl/gnd_pkg.sv
package gnd_pkg;

  localparam int NOTE_KINDS  = 8;
  localparam int KIND_W      = 3;
  localparam int AMOUNT_W    = 18;
  localparam int STOCK_W     = 14;
  localparam int VALUE_W     = 9;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;

  localparam logic [AMOUNT_W-1:0] TOTAL_RESET = 18'd173600;
  localparam logic [KIND_W-1:0]   KIND_LAST   = 3'd7;

  typedef logic [KIND_W-1:0] kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EST,
    ST_TAKE,
    ST_DONE
  } state_t;

  function automatic logic [VALUE_W-1:0] note_value(kind_t k);
    logic [VALUE_W-1:0] v;
    unique case (k)
      3'd0: v = 9'd500;
      3'd1: v = 9'd150;
      3'd2: v = 9'd50;
      3'd3: v = 9'd20;
      3'd4: v = 9'd10;
      3'd5: v = 9'd5;
      3'd6: v = 9'd2;
      3'd7: v = 9'd1;
    endcase
    return v;
  endfunction

  function automatic logic [RECIP_W-1:0] note_recip(kind_t k);
    logic [RECIP_W-1:0] m;
    unique case (k)
      3'd0: m = 25'd33554;
      3'd1: m = 25'd111848;
      3'd2: m = 25'd335544;
      3'd3: m = 25'd838860;
      3'd4: m = 25'd1677721;
      3'd5: m = 25'd3355443;
      3'd6: m = 25'd8388608;
      3'd7: m = 25'd16777216;
    endcase
    return m;
  endfunction

  function automatic logic [STOCK_W-1:0] stock_reset(kind_t k);
    logic [STOCK_W-1:0] s;
    unique case (k)
      3'd0: s = 14'd100;
      3'd1: s = 14'd200;
      3'd2: s = 14'd400;
      3'd3: s = 14'd800;
      3'd4: s = 14'd1600;
      3'd5: s = 14'd3200;
      3'd6: s = 14'd6400;
      3'd7: s = 14'd12800;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/greedy_note_dispenser_core.sv
// Cash dispenser core with a stock of notes in eight values (500, 150, 50, 20, 10, 5, 2, 1).
// Each amount transaction is refused when the stock value is below it; otherwise notes are
// taken greedily from the largest value down, limited by stock, and the unpaid rest is
// reported as shortfall (notes already taken stay taken). The stock lives in an 8-entry
// memory with a registered read; each note value goes through a reciprocal multiply,
// a back-multiply with memory read data and a correct/limit/write back, while a refused
// amount skips the walk. A new amount is accepted while the previous result still waits in
// the output register.
module greedy_note_dispenser_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gnd_pkg::AMOUNT_W-1:0]   amount,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           granted,
  output logic [6:0]                     count_500,
  output logic [7:0]                     count_150,
  output logic [8:0]                     count_50,
  output logic [9:0]                     count_20,
  output logic [10:0]                    count_10,
  output logic [11:0]                    count_5,
  output logic [12:0]                    count_2,
  output logic [13:0]                    count_1,
  output logic [gnd_pkg::AMOUNT_W-1:0]   shortfall
);

  gnd_pkg::state_t state, state_next;

  logic [gnd_pkg::AMOUNT_W-1:0] amount_r;
  logic [gnd_pkg::AMOUNT_W-1:0] rest;
  logic [gnd_pkg::AMOUNT_W-1:0] total;
  logic [gnd_pkg::AMOUNT_W-1:0] q_est;
  logic [gnd_pkg::AMOUNT_W-1:0] qv;
  logic [gnd_pkg::AMOUNT_W-1:0] sv;
  logic [gnd_pkg::STOCK_W-1:0]  stock_cur;
  gnd_pkg::kind_t               kind;
  logic                         granted_r;
  logic [gnd_pkg::STOCK_W-1:0]  count [gnd_pkg::NOTE_KINDS];

  logic [gnd_pkg::STOCK_W-1:0]    stock_mem [gnd_pkg::NOTE_KINDS];
  logic [gnd_pkg::NOTE_KINDS-1:0] stock_vld;
  logic [gnd_pkg::STOCK_W-1:0]    rd_data;
  logic                           rd_vld;

  logic                                                  accept;
  logic                                                  refuse;
  logic                                                  load_out;
  logic [gnd_pkg::VALUE_W-1:0]                           value;
  logic [gnd_pkg::AMOUNT_W+gnd_pkg::RECIP_W-1:0]         prod;
  logic [gnd_pkg::AMOUNT_W+gnd_pkg::VALUE_W-1:0]         qv_full;
  logic [gnd_pkg::AMOUNT_W+gnd_pkg::VALUE_W-1:0]         sv_full;
  logic [gnd_pkg::STOCK_W-1:0]                           stock_now;
  logic [gnd_pkg::AMOUNT_W-1:0]                          r;
  logic                                                  fix;
  logic [gnd_pkg::AMOUNT_W-1:0]                          q_fix;
  logic [gnd_pkg::AMOUNT_W-1:0]                          r_fix;
  logic                                                  over;
  logic [gnd_pkg::STOCK_W-1:0]                           take;
  logic [gnd_pkg::AMOUNT_W-1:0]                          rest_next;

  assign accept   = in_valid && !in_stall;
  assign refuse   = total < amount;
  assign load_out = (state == gnd_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign value    = gnd_pkg::note_value(kind);

  assign prod      = {{gnd_pkg::RECIP_W{1'b0}}, rest}
                   * {{gnd_pkg::AMOUNT_W{1'b0}}, gnd_pkg::note_recip(kind)};
  assign stock_now = rd_vld ? rd_data : gnd_pkg::stock_reset(kind);
  assign qv_full   = {{gnd_pkg::VALUE_W{1'b0}}, q_est}
                   * {{gnd_pkg::AMOUNT_W{1'b0}}, value};
  assign sv_full   = {{(gnd_pkg::AMOUNT_W+gnd_pkg::VALUE_W-gnd_pkg::STOCK_W){1'b0}}, stock_now}
                   * {{gnd_pkg::AMOUNT_W{1'b0}}, value};

  assign r         = rest - qv;
  assign fix       = r >= {{(gnd_pkg::AMOUNT_W-gnd_pkg::VALUE_W){1'b0}}, value};
  assign q_fix     = q_est + {{(gnd_pkg::AMOUNT_W-1){1'b0}}, fix};
  assign r_fix     = fix ? r - {{(gnd_pkg::AMOUNT_W-gnd_pkg::VALUE_W){1'b0}}, value} : r;
  assign over      = q_fix > {{(gnd_pkg::AMOUNT_W-gnd_pkg::STOCK_W){1'b0}}, stock_cur};
  assign take      = over ? stock_cur : q_fix[gnd_pkg::STOCK_W-1:0];
  assign rest_next = over ? rest - sv : r_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gnd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      gnd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = refuse ? gnd_pkg::ST_DONE : gnd_pkg::ST_MUL;
        end
      end
      gnd_pkg::ST_MUL: state_next = gnd_pkg::ST_EST;
      gnd_pkg::ST_EST: state_next = gnd_pkg::ST_TAKE;
      gnd_pkg::ST_TAKE: begin
        state_next = (kind == gnd_pkg::KIND_LAST) ? gnd_pkg::ST_DONE : gnd_pkg::ST_MUL;
      end
      gnd_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = gnd_pkg::ST_IDLE;
        end
      end
      default: state_next = gnd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == gnd_pkg::ST_MUL) begin
      rd_data <= stock_mem[kind];
    end
    if (state == gnd_pkg::ST_TAKE) begin
      stock_mem[kind] <= stock_cur - take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stock_vld <= '0;
      total     <= gnd_pkg::TOTAL_RESET;
      out_valid <= 1'b0;
    end else begin
      if (state == gnd_pkg::ST_TAKE) begin
        stock_vld[kind] <= 1'b1;
      end
      if (load_out && granted_r) begin
        total <= total - amount_r + rest;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == gnd_pkg::ST_MUL) begin
      rd_vld <= stock_vld[kind];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gnd_pkg::ST_IDLE: begin
        if (accept) begin
          amount_r  <= amount;
          kind      <= '0;
          granted_r <= !refuse;
          rest      <= refuse ? '0 : amount;
          for (int i = 0; i < gnd_pkg::NOTE_KINDS; i++) begin
            count[i] <= '0;
          end
        end
      end
      gnd_pkg::ST_MUL: begin
        q_est <= prod[gnd_pkg::RECIP_SHIFT +: gnd_pkg::AMOUNT_W];
      end
      gnd_pkg::ST_EST: begin
        qv        <= qv_full[gnd_pkg::AMOUNT_W-1:0];
        sv        <= sv_full[gnd_pkg::AMOUNT_W-1:0];
        stock_cur <= stock_now;
      end
      gnd_pkg::ST_TAKE: begin
        rest        <= rest_next;
        count[kind] <= take;
        kind        <= kind + 1'b1;
      end
      gnd_pkg::ST_DONE: begin
        if (load_out) begin
          granted   <= granted_r;
          count_500 <= count[0][6:0];
          count_150 <= count[1][7:0];
          count_50  <= count[2][8:0];
          count_20  <= count[3][9:0];
          count_10  <= count[4][10:0];
          count_5   <= count[5][11:0];
          count_2   <= count[6][12:0];
          count_1   <= count[7][13:0];
          shortfall <= rest;
        end
      end
      default: begin
      end
    endcase
  end

  a_refuse_skips_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && refuse) |=> (state == gnd_pkg::ST_DONE) && !granted_r && (rest == '0))
    else $error("refused transaction entered the note walk");

  a_refused_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (shortfall == '0) && (count_1 == '0) && (count_500 == '0))
    else $error("refused result carries nonzero fields");

  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    total <= gnd_pkg::TOTAL_RESET)
    else $error("stock value above its reset value");

  a_take_within_stock: assert property (@(posedge clk) disable iff (rst)
    (state == gnd_pkg::ST_TAKE) |-> (take <= stock_cur) && (rest_next <= rest))
    else $error("note count exceeds stock or rest grew");

  a_walk_advances: assert property (@(posedge clk) disable iff (rst)
    (state == gnd_pkg::ST_TAKE && kind != gnd_pkg::KIND_LAST) |=>
      (state == gnd_pkg::ST_MUL) && (kind == $past(kind) + 1'b1))
    else $error("note walk skipped a value");

endmodule

FILE: verif/gnd_payout_checker.sv
`timescale 1ns / 100ps

module gnd_payout_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [gnd_pkg::AMOUNT_W-1:0] amount,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         granted,
  input  logic [6:0]                   count_500,
  input  logic [7:0]                   count_150,
  input  logic [8:0]                   count_50,
  input  logic [9:0]                   count_20,
  input  logic [10:0]                  count_10,
  input  logic [11:0]                  count_5,
  input  logic [12:0]                  count_2,
  input  logic [13:0]                  count_1,
  input  logic [gnd_pkg::AMOUNT_W-1:0] shortfall,
  output int                           errors,
  output int                           pending,
  output int                           n_granted,
  output int                           n_refused,
  output int                           n_short
);

  typedef logic [gnd_pkg::STOCK_W-1:0]  notes_t;
  typedef logic [gnd_pkg::AMOUNT_W-1:0] amount_t;

  typedef struct {
    logic    granted;
    notes_t  notes [gnd_pkg::NOTE_KINDS];
    amount_t unpaid;
  } payout_t;

  notes_t  stock [gnd_pkg::NOTE_KINDS];
  payout_t owed [$];
  int      pushed = 0;
  int      popped = 0;

  assign pending = pushed - popped;

  function automatic int unsigned denom(int k);
    case (k)
      0:       return 500;
      1:       return 150;
      2:       return 50;
      3:       return 20;
      4:       return 10;
      5:       return 5;
      6:       return 2;
      default: return 1;
    endcase
  endfunction

  function automatic notes_t full_stock(int k);
    case (k)
      0:       return 14'd100;
      1:       return 14'd200;
      2:       return 14'd400;
      3:       return 14'd800;
      4:       return 14'd1600;
      5:       return 14'd3200;
      6:       return 14'd6400;
      default: return 14'd12800;
    endcase
  endfunction

  function automatic string note_name(int k);
    case (k)
      0:       return "count_500";
      1:       return "count_150";
      2:       return "count_50";
      3:       return "count_20";
      4:       return "count_10";
      5:       return "count_5";
      6:       return "count_2";
      default: return "count_1";
    endcase
  endfunction

  // Refuse when the stock is worth less than the amount; otherwise pay
  // greedily from the largest note and keep whatever cannot be paid.
  function automatic payout_t dispense(amount_t amt);
    payout_t     p;
    int unsigned worth;
    int unsigned rest;
    int unsigned take;
    worth = 0;
    for (int k = 0; k < gnd_pkg::NOTE_KINDS; k++) worth += 32'(stock[k]) * denom(k);
    p.granted = (worth >= 32'(amt));
    rest = 32'(amt);
    for (int k = 0; k < gnd_pkg::NOTE_KINDS; k++) begin
      take = 0;
      if (p.granted && rest >= denom(k)) begin
        take = rest / denom(k);
        if (take > 32'(stock[k])) take = 32'(stock[k]);
        rest -= take * denom(k);
        stock[k] = stock[k] - notes_t'(take);
      end
      p.notes[k] = notes_t'(take);
    end
    p.unpaid = p.granted ? amount_t'(rest) : '0;
    return p;
  endfunction

  always @(posedge clk) begin : watch
    payout_t exp_p;
    notes_t  seen [gnd_pkg::NOTE_KINDS];
    int      bad;
    bad = 0;
    if (rst) begin
      for (int k = 0; k < gnd_pkg::NOTE_KINDS; k++) stock[k] = full_stock(k);
      owed.delete();
      pushed    <= 0;
      popped    <= 0;
      errors    <= 0;
      n_granted <= 0;
      n_refused <= 0;
      n_short   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed.size() == 0) begin
          $error("payout transaction with no request outstanding");
          bad++;
        end else begin
          exp_p   = owed.pop_front();
          seen[0] = notes_t'(count_500);
          seen[1] = notes_t'(count_150);
          seen[2] = notes_t'(count_50);
          seen[3] = notes_t'(count_20);
          seen[4] = notes_t'(count_10);
          seen[5] = notes_t'(count_5);
          seen[6] = notes_t'(count_2);
          seen[7] = notes_t'(count_1);
          if (granted !== exp_p.granted) begin
            $error("granted: expected %0d, actual %0d", exp_p.granted, granted);
            bad++;
          end
          for (int k = 0; k < gnd_pkg::NOTE_KINDS; k++) begin
            if (seen[k] !== exp_p.notes[k]) begin
              $error("%s: expected %0d, actual %0d", note_name(k), exp_p.notes[k], seen[k]);
              bad++;
            end
          end
          if (shortfall !== exp_p.unpaid) begin
            $error("shortfall: expected %0d, actual %0d", exp_p.unpaid, shortfall);
            bad++;
          end
          if (exp_p.granted) begin
            n_granted <= n_granted + 1;
            if (exp_p.unpaid != 0) n_short <= n_short + 1;
          end else begin
            n_refused <= n_refused + 1;
          end
        end
        popped <= popped + 1;
      end
      if (in_valid && !in_stall) begin
        owed.push_back(dispense(amount));
        pushed <= pushed + 1;
      end
      errors <= errors + bad;
    end
  end

endmodule

FILE: verif/greedy_note_dispenser_core_tb.sv
`timescale 1ns / 100ps

module greedy_note_dispenser_core_tb;

  localparam int RANDOM_ITEMS = 730;

  typedef logic [gnd_pkg::AMOUNT_W-1:0] amount_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  amount_t    amount    = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       granted;
  logic [6:0] count_500;
  logic [7:0] count_150;
  logic [8:0] count_50;
  logic [9:0] count_20;
  logic [10:0] count_10;
  logic [11:0] count_5;
  logic [12:0] count_2;
  logic [13:0] count_1;
  amount_t    shortfall;

  int errors;
  int pending;
  int n_granted;
  int n_refused;
  int n_short;
  bit in_burst = 1'b0;

  greedy_note_dispenser_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .amount    (amount),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .granted   (granted),
    .count_500 (count_500),
    .count_150 (count_150),
    .count_50  (count_50),
    .count_20  (count_20),
    .count_10  (count_10),
    .count_5   (count_5),
    .count_2   (count_2),
    .count_1   (count_1),
    .shortfall (shortfall)
  );

  gnd_payout_checker payout_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .amount    (amount),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .granted   (granted),
    .count_500 (count_500),
    .count_150 (count_150),
    .count_50  (count_50),
    .count_20  (count_20),
    .count_10  (count_10),
    .count_5   (count_5),
    .count_2   (count_2),
    .count_1   (count_1),
    .shortfall (shortfall),
    .errors    (errors),
    .pending   (pending),
    .n_granted (n_granted),
    .n_refused (n_refused),
    .n_short   (n_short)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stall_gen
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r < 70) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 90) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (in_burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // Mostly modest withdrawals so the stock lasts well into the run.
  function automatic amount_t pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return amount_t'($urandom_range(0, 400));
    if (r < 75) return amount_t'($urandom_range(0, 15));
    if (r < 90) return amount_t'($urandom_range(401, 1500));
    if (r < 97) return amount_t'($urandom_range(1501, 8000));
    return amount_t'($urandom_range(0, (1 << gnd_pkg::AMOUNT_W) - 1));
  endfunction

  task automatic offer(input amount_t a);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    amount   <= a;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned opening [24];
    opening = '{0, 262143, 173601, 1, 2, 3, 4, 7, 9, 19, 20, 49, 50, 149, 150,
                499, 500, 688, 52345, 500, 1000, 172, 1337, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (opening[i]) offer(amount_t'(opening[i]));
    hold_until_drained();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      offer(pick_amount());
    end
    hold_until_drained();
    repeat (40) @(posedge clk);
    $display("Run covered %0d granted withdrawals (%0d left a shortfall)", n_granted, n_short);
    $display("and %0d refused ones, with random gaps and output stalls", n_refused);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/gnd_pkg.sv
hdl/greedy_note_dispenser_core.sv
verif/gnd_payout_checker.sv
verif/greedy_note_dispenser_core_tb.sv
